>>> hw/rtl/rdf_pkg.sv
package rdf_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int ADDRESS_BITS  = 16;
  localparam int SRC_W         = 16;
  localparam int SEQ_W         = 8;
  localparam int HOP_W         = 8;
  localparam int VERDICT_W     = 3;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_ACCEPT    = 3'd0,
    VERDICT_OWN_SRC   = 3'd1,
    VERDICT_DUPLICATE = 3'd2,
    VERDICT_NO_BUFFER = 3'd3,
    VERDICT_HOP_EXP   = 3'd4,
    VERDICT_QUEUE_FUL = 3'd5
  } verdict_t;

  typedef struct packed {
    logic [ADDRESS_BITS-1:0] addr;
    logic [SEQ_W-1:0]        seq;
  } entry_t;

  // match status passed down the row of cells
  typedef struct packed {
    logic hit;
    logic dup;
  } chain_t;

endpackage

>>> hw/rtl/rdf_cell.sv
module rdf_cell import rdf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  entry_t key,
  input  logic   update,
  input  entry_t up_entry,
  input  chain_t chain_in,
  output entry_t entry,
  output chain_t chain_out
);

  logic match;

  assign match = (entry.addr == key.addr);

  // first matching cell decides the duplicate check
  assign chain_out.hit = chain_in.hit | match;
  assign chain_out.dup = chain_in.dup |
                         (match & ~chain_in.hit & (entry.seq == key.seq));

  // cells up to and including the first match take their neighbor's pair
  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (update && !chain_in.hit) begin
      entry <= up_entry;
    end
  end

endmodule

>>> hw/rtl/rdf_table.sv
module rdf_table import rdf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  entry_t key,
  input  logic   update,
  output logic   dup
);

  entry_t entries [TABLE_ENTRIES];
  chain_t chain   [TABLE_ENTRIES+1];

  assign chain[0] = '0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    entry_t up;
    if (i == 0) begin : g_head
      assign up = key;
    end else begin : g_body
      assign up = entries[i-1];
    end
    rdf_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .key       (key),
      .update    (update),
      .up_entry  (up),
      .chain_in  (chain[i]),
      .entry     (entries[i]),
      .chain_out (chain[i+1])
    );
  end

  assign dup = chain[TABLE_ENTRIES].dup;

endmodule

>>> hw/rtl/receive_duplicate_filter_core.sv
// path: each input beat is captured into the header registers, then decided and loaded into the result register
// a new header is not taken until the pending one is decided; one is taken while the last result waits
// the decide cycle is the compare ripple through the row of sender/sequence cells
// reset: synchronous active-high rst clears the whole table to zeros, own address to 0
// and drops any pending header and result
module receive_duplicate_filter_core import rdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // own address register
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  // header beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] source_address, [23:16] sequence_number, [31:24] hop_limit,
  // [32] buffer_free, [33] queue_accepts, [34] queue_was_empty, [39:35] zero
  input  logic [39:0] s_axis_tdata,
  // verdict beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] verdict, [10:3] new_hop_limit, [11] wake_core, [15:12] zero
  output logic [15:0] m_axis_tdata
);

  // own address register
  logic [SRC_W-1:0] own_address;

  // captured header
  logic             pend;
  logic [SRC_W-1:0] src;
  logic [SEQ_W-1:0] seq;
  logic [HOP_W-1:0] hop;
  logic             buf_ok;
  logic             q_ok;
  logic             q_empty;

  // result register
  verdict_t         verdict;
  logic [HOP_W-1:0] new_hop_limit;
  logic             wake_core;

  // decide step
  entry_t           key;
  logic             dup;
  logic             fire;
  logic             update;
  verdict_t         verdict_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= '0;
    end else if (cfg_wr_en) begin
      own_address <= cfg_wr_data;
    end
  end

  // one header held at a time
  assign s_axis_tready = !pend;

  // decide when the result register is free or being emptied
  assign fire = pend && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      pend <= 1'b1;
    end else if (fire) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      src     <= s_axis_tdata[15:0];
      seq     <= s_axis_tdata[23:16];
      hop     <= s_axis_tdata[31:24];
      buf_ok  <= s_axis_tdata[32];
      q_ok    <= s_axis_tdata[33];
      q_empty <= s_axis_tdata[34];
    end
  end

  // the table key is the low ADDRESS_BITS of the source, which here is the whole source address
  assign key.addr = src[ADDRESS_BITS-1:0];
  assign key.seq  = seq;

  rdf_table u_table (
    .clk    (clk),
    .rst    (rst),
    .key    (key),
    .update (update),
    .dup    (dup)
  );

  // drop reasons in priority order
  always_comb begin
    if (key.addr == own_address[ADDRESS_BITS-1:0]) begin
      verdict_next = VERDICT_OWN_SRC;
    end else if (dup) begin
      verdict_next = VERDICT_DUPLICATE;
    end else if (!buf_ok) begin
      verdict_next = VERDICT_NO_BUFFER;
    end else if (hop == '0) begin
      verdict_next = VERDICT_HOP_EXP;
    end else if (!q_ok) begin
      verdict_next = VERDICT_QUEUE_FUL;
    end else begin
      verdict_next = VERDICT_ACCEPT;
    end
  end

  // table moves only on an accepted packet
  assign update = fire && (verdict_next == VERDICT_ACCEPT);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      verdict <= verdict_next;
      if (verdict_next == VERDICT_ACCEPT) begin
        new_hop_limit <= hop - 1'b1;
        wake_core     <= q_empty;
      end else begin
        new_hop_limit <= '0;
        wake_core     <= 1'b0;
      end
    end
  end

  assign m_axis_tdata = {4'b0000, wake_core, new_hop_limit, verdict};

  // a taken header blocks the input for the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a header is pending");

  // a dropped packet carries no hop limit and no wake
  a_drop_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (verdict != VERDICT_ACCEPT) |-> (new_hop_limit == '0) && !wake_core)
    else $error("dropped packet with nonzero fields");

  // a new result only comes from a pending header
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(pend))
    else $error("result without a pending header");

  // the table moves only together with a result load
  a_update_fire: assert property (@(posedge clk) disable iff (rst)
    update |=> m_axis_tvalid && (verdict == VERDICT_ACCEPT))
    else $error("table update without an accepted result");

endmodule
